FILE: sv/eased_vector_interpolator_core_assert.svh
// assertion macros for the eased vector interpolator
// expects i_clk and i_rst_n in the module that uses them
`ifndef EASED_VECTOR_INTERPOLATOR_CORE_ASSERT_SVH
`define EASED_VECTOR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define EVI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EVI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/evi_pkg.sv
// shared constants, types and the cosine easing table for the interpolator
// no dependencies
package evi_pkg;

    localparam int COS_DEPTH  = 256;
    localparam int COMPONENTS = 4;
    localparam int LANES      = 4;

    localparam int T_W     = 17;
    localparam int COORD_W = 32;
    localparam int GAIN_W  = 24;
    localparam int MODE_W  = 3;
    localparam int W_W     = 17;
    localparam int IDX_W   = $clog2(COS_DEPTH + 1);
    localparam int POS_W   = 16 + IDX_W;
    localparam int KH_W    = 17;
    localparam int KL_W    = 24;
    localparam int AD_W    = 33;
    localparam int M_W     = 50;
    localparam int SQ_W    = 2 * AD_W;
    localparam int PAIR_W  = SQ_W + 1;
    localparam int SUM_W   = SQ_W + 2;

    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 128;
    localparam int CUR_LSB    = T_W;
    localparam int TGT_LSB    = T_W + LANES * COORD_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [T_W-1:0]    ONE_Q16    = 17'h10000;
    localparam logic [63:0]       PI_Q30     = 64'd3373259426;
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd3;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd128000;

    typedef enum logic [MODE_W-1:0] {
        EASE_LINEAR     = 3'd0,
        EASE_COSINE     = 3'd1,
        EASE_SQUARE     = 3'd2,
        EASE_SMOOTH     = 3'd3,
        EASE_INV_SQUARE = 3'd4
    } t_ease_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EASE_MODE = 2'd0,
        CFG_STEP_GAIN = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [KH_W-1:0] kh;
        logic [KL_W-1:0] kl;
    } t_gain;

    typedef struct packed {
        logic signed [COORD_W-1:0] res;
        logic signed [COORD_W-1:0] tgt;
        logic [SQ_W-1:0]           osq;
        logic [SQ_W-1:0]           nsq;
    } t_lane_out;

    typedef logic [W_W-1:0] t_cos_table [0:COS_DEPTH];

    // sin^2 ramp entry by fixed-point taylor series in q2.30
    function automatic logic [W_W-1:0] cos_entry(input logic [63:0] i);
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] e;
        u    = (PI_Q30 * i) / (2 * COS_DEPTH);
        term = u;
        s    = u;
        for (int k = 1; k <= 6; k++) begin
            term = (term * u) >> 30;
            term = (term * u) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (k % 2 == 1) begin
                s = (s > term) ? s - term : 64'd0;
            end else begin
                s = s + term;
            end
        end
        e = (s * s + (64'd1 << 43)) >> 44;
        return (e > 64'(ONE_Q16)) ? ONE_Q16 : W_W'(e);
    endfunction

    function automatic t_cos_table cos_table_build();
        t_cos_table tbl;
        for (int i = 0; i <= COS_DEPTH; i++) begin
            tbl[i] = cos_entry(64'(i));
        end
        return tbl;
    endfunction

    localparam t_cos_table COS_TABLE = cos_table_build();

endpackage

FILE: sv/evi_weight.sv
// eased weight and gain product, five register stages
// depends on evi_pkg
module evi_weight (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [evi_pkg::T_W-1:0]      i_time,
    input  logic [evi_pkg::MODE_W-1:0]   i_mode,
    input  logic [evi_pkg::GAIN_W-1:0]   i_gain,
    output evi_pkg::t_gain               o_gain
);

    logic [evi_pkg::T_W-1:0]     r1_t;

    logic [evi_pkg::T_W-1:0]     r2_t;
    logic [33:0]                 r2_sq;
    logic [33:0]                 r2_rsq;
    logic [17:0]                 r2_m3;
    logic [evi_pkg::IDX_W-1:0]   r2_idx;
    logic [15:0]                 r2_frac;

    logic [evi_pkg::T_W-1:0]     r3_t;
    logic [33:0]                 r3_sq;
    logic [33:0]                 r3_rsq;
    logic [51:0]                 r3_ss;
    logic [evi_pkg::W_W-1:0]     r3_ca;
    logic [32:0]                 r3_cp;

    logic [evi_pkg::W_W-1:0]     r4_w;
    evi_pkg::t_gain              r5_gain;

    logic [evi_pkg::T_W-1:0]     n1_t;
    logic [evi_pkg::T_W-1:0]     n2_r;
    logic [evi_pkg::POS_W-1:0]   n2_pos;
    logic [evi_pkg::IDX_W-1:0]   n3_idx_nx;
    logic [evi_pkg::W_W-1:0]     n3_cb;
    logic [evi_pkg::W_W-1:0]     n4_w;
    logic [40:0]                 n5_k;

    always_comb begin
        n1_t      = (i_time > evi_pkg::ONE_Q16) ? evi_pkg::ONE_Q16 : i_time;
        n2_r      = evi_pkg::ONE_Q16 - r1_t;
        n2_pos    = evi_pkg::POS_W'(r1_t) * evi_pkg::POS_W'(evi_pkg::COS_DEPTH);
        n3_idx_nx = (r2_idx >= evi_pkg::IDX_W'(evi_pkg::COS_DEPTH)) ? r2_idx
                                                                    : r2_idx + 1'b1;
        n3_cb     = evi_pkg::COS_TABLE[n3_idx_nx];
        if (n3_cb < evi_pkg::COS_TABLE[r2_idx]) begin
            n3_cb = evi_pkg::COS_TABLE[r2_idx];
        end
        case (evi_pkg::t_ease_mode'(i_mode))
            evi_pkg::EASE_COSINE:
                n4_w = r3_ca + evi_pkg::W_W'((r3_cp + 33'd32768) >> 16);
            evi_pkg::EASE_SQUARE:
                n4_w = evi_pkg::W_W'((r3_sq + 34'd32768) >> 16);
            evi_pkg::EASE_SMOOTH:
                n4_w = evi_pkg::W_W'((r3_ss + (52'd1 << 47)) >> 48);
            evi_pkg::EASE_INV_SQUARE:
                n4_w = evi_pkg::ONE_Q16 - evi_pkg::W_W'((r3_rsq + 34'd32768) >> 16);
            default:
                n4_w = r3_t;
        endcase
        n5_k = 41'(r4_w) * 41'(i_gain);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t    <= n1_t;

            r2_t    <= r1_t;
            r2_sq   <= 34'(r1_t) * 34'(r1_t);
            r2_rsq  <= 34'(n2_r) * 34'(n2_r);
            r2_m3   <= 18'd196608 - {r1_t, 1'b0};
            r2_idx  <= n2_pos[evi_pkg::POS_W-1:16];
            r2_frac <= n2_pos[15:0];

            r3_t    <= r2_t;
            r3_sq   <= r2_sq;
            r3_rsq  <= r2_rsq;
            r3_ss   <= 52'(r2_sq) * 52'(r2_m3);
            r3_ca   <= evi_pkg::COS_TABLE[r2_idx];
            r3_cp   <= 33'(n3_cb - evi_pkg::COS_TABLE[r2_idx]) * 33'(r2_frac);

            r4_w    <= n4_w;

            r5_gain.kh <= n5_k[40:24];
            r5_gain.kl <= n5_k[23:0];
        end
    end

    assign o_gain = r5_gain;

endmodule

FILE: sv/evi_lane.sv
// one component lane: step toward target, saturate, squared distances
// depends on evi_pkg; gain arrives from evi_weight at lane stage six
module evi_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [evi_pkg::COORD_W-1:0] i_cur,
    input  logic signed [evi_pkg::COORD_W-1:0] i_tgt,
    input  evi_pkg::t_gain                     i_gain,
    output evi_pkg::t_lane_out                 o_lane
);

    logic signed [evi_pkg::COORD_W-1:0] r1_cur, r1_tgt;

    logic signed [evi_pkg::COORD_W-1:0] r2_cur, r3_cur, r4_cur, r5_cur, r6_cur, r7_cur;
    logic signed [evi_pkg::COORD_W-1:0] r2_tgt, r3_tgt, r4_tgt, r5_tgt, r6_tgt, r7_tgt;
    logic signed [evi_pkg::COORD_W-1:0] r8_tgt, r9_tgt, r10_tgt;
    logic                               r2_neg, r3_neg, r4_neg, r5_neg, r6_neg, r7_neg;
    logic [evi_pkg::AD_W-1:0]           r2_ad, r3_ad, r4_ad, r5_ad;
    logic [evi_pkg::SQ_W-1:0]           r3_osq, r4_osq, r5_osq, r6_osq, r7_osq;
    logic [evi_pkg::SQ_W-1:0]           r8_osq, r9_osq, r10_osq;
    logic [evi_pkg::M_W-1:0]            r6_p1;
    logic [56:0]                        r6_p2;
    logic [evi_pkg::M_W-1:0]            r7_m;
    logic signed [evi_pkg::COORD_W-1:0] r8_res, r9_res, r10_res;
    logic [evi_pkg::AD_W-1:0]           r9_ae;
    logic [evi_pkg::SQ_W-1:0]           r10_nsq;

    logic signed [evi_pkg::AD_W-1:0]    n2_d;
    logic signed [51:0]                 n8_v;
    logic signed [evi_pkg::COORD_W-1:0] n8_res;
    logic signed [evi_pkg::AD_W-1:0]    n9_e;

    always_comb begin
        n2_d = evi_pkg::AD_W'(r1_tgt) - evi_pkg::AD_W'(r1_cur);
        n8_v = r7_neg ? 52'(r7_cur) - signed'({2'b00, r7_m})
                      : 52'(r7_cur) + signed'({2'b00, r7_m});
        if (n8_v[51:31] == '0 || n8_v[51:31] == '1) begin
            n8_res = n8_v[31:0];
        end else if (n8_v[51]) begin
            n8_res = 32'sh80000000;
        end else begin
            n8_res = 32'sh7FFFFFFF;
        end
        n9_e = evi_pkg::AD_W'(r8_res) - evi_pkg::AD_W'(r8_tgt);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cur  <= i_cur;
            r1_tgt  <= i_tgt;

            r2_cur  <= r1_cur;
            r2_tgt  <= r1_tgt;
            r2_neg  <= n2_d[evi_pkg::AD_W-1];
            r2_ad   <= n2_d[evi_pkg::AD_W-1] ? -n2_d : n2_d;

            r3_cur  <= r2_cur;
            r3_tgt  <= r2_tgt;
            r3_neg  <= r2_neg;
            r3_ad   <= r2_ad;
            r3_osq  <= evi_pkg::SQ_W'(r2_ad) * evi_pkg::SQ_W'(r2_ad);

            r4_cur  <= r3_cur;
            r4_tgt  <= r3_tgt;
            r4_neg  <= r3_neg;
            r4_ad   <= r3_ad;
            r4_osq  <= r3_osq;

            r5_cur  <= r4_cur;
            r5_tgt  <= r4_tgt;
            r5_neg  <= r4_neg;
            r5_ad   <= r4_ad;
            r5_osq  <= r4_osq;

            r6_cur  <= r5_cur;
            r6_tgt  <= r5_tgt;
            r6_neg  <= r5_neg;
            r6_osq  <= r5_osq;
            r6_p1   <= evi_pkg::M_W'(r5_ad) * evi_pkg::M_W'(i_gain.kh);
            r6_p2   <= 57'(r5_ad) * 57'(i_gain.kl);

            r7_cur  <= r6_cur;
            r7_tgt  <= r6_tgt;
            r7_neg  <= r6_neg;
            r7_osq  <= r6_osq;
            r7_m    <= r6_p1 + evi_pkg::M_W'((r6_p2 + 57'h800000) >> 24);

            r8_tgt  <= r7_tgt;
            r8_osq  <= r7_osq;
            r8_res  <= n8_res;

            r9_tgt  <= r8_tgt;
            r9_osq  <= r8_osq;
            r9_res  <= r8_res;
            r9_ae   <= n9_e[evi_pkg::AD_W-1] ? -n9_e : n9_e;

            r10_tgt <= r9_tgt;
            r10_osq <= r9_osq;
            r10_res <= r9_res;
            r10_nsq <= evi_pkg::SQ_W'(r9_ae) * evi_pkg::SQ_W'(r9_ae);
        end
    end

    assign o_lane.res = r10_res;
    assign o_lane.tgt = r10_tgt;
    assign o_lane.osq = r10_osq;
    assign o_lane.nsq = r10_nsq;

endmodule

FILE: sv/evi_merge.sv
// merges the lanes: summed squared distances, overshoot compare, output register
// depends on evi_pkg; lane results come from evi_lane
module evi_merge (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  evi_pkg::t_lane_out                   i_lane [evi_pkg::LANES],
    output logic [evi_pkg::OUT_DATA_W-1:0]       o_data,
    output logic                                 o_snap
);

    logic [evi_pkg::PAIR_W-1:0]                      r11_o01, r11_o23, r11_n01, r11_n23;
    logic [evi_pkg::LANES-1:0][evi_pkg::COORD_W-1:0] r11_res, r11_tgt;
    logic [evi_pkg::SUM_W-1:0]                       r12_osum, r12_nsum;
    logic [evi_pkg::LANES-1:0][evi_pkg::COORD_W-1:0] r12_res, r12_tgt;
    logic [evi_pkg::OUT_DATA_W-1:0]                  r13_data;
    logic                                            r13_snap;

    logic [evi_pkg::LANES-1:0][evi_pkg::SQ_W-1:0]    n11_osq, n11_nsq;
    logic [evi_pkg::LANES-1:0][evi_pkg::COORD_W-1:0] n11_res, n11_tgt;
    logic                                            n13_snap;

    // components past the configured count stay on target and skip the distances
    always_comb begin
        for (int c = 0; c < evi_pkg::LANES; c++) begin
            n11_tgt[c] = i_lane[c].tgt;
            if (c < evi_pkg::COMPONENTS) begin
                n11_osq[c] = i_lane[c].osq;
                n11_nsq[c] = i_lane[c].nsq;
                n11_res[c] = i_lane[c].res;
            end else begin
                n11_osq[c] = '0;
                n11_nsq[c] = '0;
                n11_res[c] = i_lane[c].tgt;
            end
        end
        n13_snap = r12_nsum > r12_osum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r11_o01  <= evi_pkg::PAIR_W'(n11_osq[0]) + evi_pkg::PAIR_W'(n11_osq[1]);
            r11_o23  <= evi_pkg::PAIR_W'(n11_osq[2]) + evi_pkg::PAIR_W'(n11_osq[3]);
            r11_n01  <= evi_pkg::PAIR_W'(n11_nsq[0]) + evi_pkg::PAIR_W'(n11_nsq[1]);
            r11_n23  <= evi_pkg::PAIR_W'(n11_nsq[2]) + evi_pkg::PAIR_W'(n11_nsq[3]);
            r11_res  <= n11_res;
            r11_tgt  <= n11_tgt;

            r12_osum <= evi_pkg::SUM_W'(r11_o01) + evi_pkg::SUM_W'(r11_o23);
            r12_nsum <= evi_pkg::SUM_W'(r11_n01) + evi_pkg::SUM_W'(r11_n23);
            r12_res  <= r11_res;
            r12_tgt  <= r11_tgt;

            r13_data <= n13_snap ? r12_tgt : r12_res;
            r13_snap <= n13_snap;
        end
    end

    assign o_data = r13_data;
    assign o_snap = r13_snap;

endmodule

FILE: sv/eased_vector_interpolator_core.sv
// top level of the eased vector interpolator: config registers, valid pipeline
// depends on evi_pkg, evi_weight, evi_lane, evi_merge and the assertion header
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  time fraction, current and target vector
// m_axis    out  m_axis_tvalid/m_axis_tready  moved vector, snap flag in tuser
// cfg       in   i_cfg_wr_en                  register index and write data
//
// one item per cycle unless the output stalls; the lane and merge chains set latency
// the weight chain (five stages) runs beside the lanes and feeds their multipliers
// every stage advances together, held only while the output waits on m_axis_tready
// synchronous active-low reset clears valids and config registers (mode 3, gain 500.0)
`include "eased_vector_interpolator_core_assert.svh"

module eased_vector_interpolator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // time_fraction, cur_x, cur_y, cur_z, cur_w, tgt_x, tgt_y, tgt_z, tgt_w
    input  logic [evi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x, out_y, out_z, out_w
    output logic [evi_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // snapped
    output logic [0:0]                          m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [evi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [evi_pkg::GAIN_W-1:0]          i_cfg_wdata
);

    localparam int LAT = 13;

    logic [evi_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [evi_pkg::GAIN_W-1:0] r_gain, n_gain;
    logic [LAT-1:0]             r_vld, n_vld;
    logic                       en;

    evi_pkg::t_gain             gain;
    evi_pkg::t_lane_out         lane_out [evi_pkg::LANES];

    always_comb begin
        n_mode = r_mode;
        n_gain = r_gain;
        if (i_cfg_wr_en) begin
            case (evi_pkg::t_cfg_index'(i_cfg_idx))
                evi_pkg::CFG_EASE_MODE: n_mode = i_cfg_wdata[evi_pkg::MODE_W-1:0];
                evi_pkg::CFG_STEP_GAIN: n_gain = i_cfg_wdata;
                default: ;
            endcase
        end
        en    = !r_vld[LAT-1] || m_axis_tready;
        n_vld = en ? {r_vld[LAT-2:0], s_axis_tvalid} : r_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= evi_pkg::MODE_RESET;
            r_gain <= evi_pkg::GAIN_RESET;
            r_vld  <= '0;
        end else begin
            r_mode <= n_mode;
            r_gain <= n_gain;
            r_vld  <= n_vld;
        end
    end

    evi_weight u_weight (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_time (s_axis_tdata[evi_pkg::T_W-1:0]),
        .i_mode (r_mode),
        .i_gain (r_gain),
        .o_gain (gain)
    );

    for (genvar c = 0; c < evi_pkg::LANES; c++) begin : g_lane
        evi_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cur  (s_axis_tdata[evi_pkg::CUR_LSB + c*evi_pkg::COORD_W +: evi_pkg::COORD_W]),
            .i_tgt  (s_axis_tdata[evi_pkg::TGT_LSB + c*evi_pkg::COORD_W +: evi_pkg::COORD_W]),
            .i_gain (gain),
            .o_lane (lane_out[c])
        );
    end

    evi_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lane (lane_out),
        .o_data (m_axis_tdata),
        .o_snap (m_axis_tuser[0])
    );

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];

    `EVI_ASSERT_IMP(a_out_from_pipe, $rose(m_axis_tvalid), $past(r_vld[LAT-2]), "output valid without an item behind it")
    `EVI_ASSERT_IMP(a_stall_only_on_output, !s_axis_tready, m_axis_tvalid, "input stalled with no result waiting")
    `EVI_ASSERT_NXT(a_drain_empty, m_axis_tvalid && m_axis_tready && !r_vld[LAT-2], !m_axis_tvalid, "result repeated after transfer")

endmodule
